// ===== rtl/skt_pkg.sv =====
package skt_pkg;

    localparam int KEY_W    = 32;
    localparam int IN_DW    = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;
    localparam int OUT_DW   = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [IN_DW-1:0] record_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [OUT_DW-1:0] found_data;
        logic [CNT_W-1:0]  entry_count;
    } t_out_item;

endpackage

// ===== rtl/skt_ram.sv =====
module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sorted_key_table.sv =====
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_ready  | i_in_item  (opcode, key, record_data)
// out     | output    | o_out_valid / i_out_ready| o_out_item (status, position,
//         |           |                          |   found_data, entry_count)
//
// items are taken one at a time in the idle state; each search probe reads the table RAM
// (S_PROBE) and compares the key (S_CMP), at most ceil(log2(count+1)) probes; then the
// search settles and the result is loaded in S_DONE once the output register is free
// insert and delete move the entries that lie above the position, drain the last move when
// any, and write the new entry or drop the count; reset clears the count, not the RAM
// a result waits in the output register while the next item is taken; a second one stalls
module sorted_key_table #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  skt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output skt_pkg::t_out_item  o_out_item
);

    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = KEY_W + DATA_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_INS,
        S_DEL,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_op;
    logic [KEY_W-1:0]      r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi;
    logic                  r_hit;
    logic [OUT_DW-1:0]     r_fdata;
    logic [CW-1:0]         r_next;
    logic [AW-1:0]         r_last;
    logic                  r_pend;
    logic [1:0]            r_status;
    logic [CW-1:0]         r_pos;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [MW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [MW-1:0]         wr_data;
    logic [KEY_W-1:0]      rd_key;
    logic [DATA_WIDTH-1:0] rd_pay;
    logic [63:0]           in_data_w;
    logic [63:0]           rd_pay_w;
    logic [63:0]           pos_w;
    logic [63:0]           cnt_w;
    logic [CW-1:0]         next_dn;
    logic                  out_load;

    // width adaptation of payload, position and count
    assign in_data_w = 64'(i_in_item.record_data);
    assign rd_key    = rd_data[MW-1 -: KEY_W];
    assign rd_pay    = rd_data[DATA_WIDTH-1:0];
    assign rd_pay_w  = 64'(rd_pay);
    assign pos_w     = 64'(r_pos);
    assign cnt_w     = 64'(r_count);

    // search midpoint
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign next_dn = r_next - CW'(1);

    // result register loads when it is empty or being emptied
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // table RAM access for search probes and entry moves
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_last;
        wr_data = rd_data;
        case (r_state)
            S_PROBE: begin
                rd_en = (r_lo != r_hi);
            end
            S_INS: begin
                if (r_next > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = next_dn[AW-1:0];
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_last + AW'(1);
                end else if (r_next == r_pos) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = {r_key, r_data};
                end
            end
            S_DEL: begin
                if (r_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_next[AW-1:0];
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_last - AW'(1);
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    skt_ram #(
        .WIDTH (MW),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control sequence and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_item.opcode;
                        r_key   <= i_in_item.key;
                        r_data  <= in_data_w[DATA_WIDTH-1:0];
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_hit   <= 1'b0;
                        r_fdata <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_lo != r_hi) begin
                        r_state <= S_CMP;
                    end else begin
                        // search settled on the lower bound of the key
                        r_pend <= 1'b0;
                        case (r_op)
                            OP_INSERT: begin
                                if (r_hit) begin
                                    r_status <= ST_DUPLICATE;
                                    r_pos    <= '0;
                                    r_state  <= S_DONE;
                                end else if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_pos    <= '0;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_pos    <= r_lo;
                                    r_next   <= r_count;
                                    r_state  <= S_INS;
                                end
                            end
                            OP_DELETE: begin
                                if (!r_hit) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_pos    <= '0;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_pos    <= r_lo;
                                    r_next   <= r_lo + CW'(1);
                                    r_state  <= S_DEL;
                                end
                            end
                            OP_FIND: begin
                                if (!r_hit) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_pos    <= '0;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_pos    <= r_lo;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_DONE;
                                r_pos    <= '0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (rd_key < r_key) begin
                        r_lo <= mid + CW'(1);
                    end else begin
                        r_hi <= mid;
                    end
                    if (rd_key == r_key) begin
                        r_hit   <= 1'b1;
                        r_fdata <= rd_pay_w[OUT_DW-1:0];
                    end
                    r_state <= S_PROBE;
                end
                S_INS: begin
                    // move entries up from the top, then write the new one
                    r_pend <= (r_next > r_pos);
                    if (r_next > r_pos) begin
                        r_next <= next_dn;
                        r_last <= next_dn[AW-1:0];
                    end
                    if (!r_pend && (r_next == r_pos)) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DEL: begin
                    // move entries down over the removed one
                    r_pend <= (r_next < r_count);
                    if (r_next < r_count) begin
                        r_next <= r_next + CW'(1);
                        r_last <= r_next[AW-1:0];
                    end
                    if (!r_pend && !(r_next < r_count)) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.status      <= r_status;
                        r_out.position    <= pos_w[POS_W-1:0];
                        r_out.found_data  <= (r_op == OP_FIND && r_status == ST_DONE)
                                             ? r_fdata : '0;
                        r_out.entry_count <= cnt_w[CNT_W-1:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== bench/sorted_key_table_tb.sv =====
module sorted_key_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // shadow copy of the sorted table
    logic [KEY_W-1:0] tab_key [TABLE_DEPTH];
    logic [IN_DW-1:0] tab_data [TABLE_DEPTH];
    int               tab_cnt;

    t_out_item        pending_results[$];
    int               mismatches;
    logic [KEY_W-1:0] key_pool [32];

    // idling control: no_gaps is shared by sender and receiver, the rest is the receiver's
    bit no_gaps;
    int rx_hold_left;
    int rx_stall_left;

    sorted_key_table #(
        .CAPACITY   (TABLE_DEPTH),
        .DATA_WIDTH (IN_DW)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #1 clk = ~clk;

    // run the operation on the shadow table and return the expected result
    function automatic t_out_item table_apply(input t_in_item it);
        t_out_item r;
        int        hit;
        int        slot;
        r = '0;
        r.status = ST_DONE;
        hit = -1;
        for (int i = 0; i < tab_cnt; i++) begin
            if (hit < 0 && tab_key[i] == it.key) hit = i;
        end
        case (it.opcode)
            OP_INSERT: begin
                if (hit >= 0) begin
                    r.status = ST_DUPLICATE;
                end else if (tab_cnt >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = tab_cnt;
                    for (int i = tab_cnt - 1; i >= 0; i--) begin
                        if (tab_key[i] > it.key) slot = i;
                    end
                    for (int j = tab_cnt; j > slot; j--) begin
                        tab_key[j]  = tab_key[j-1];
                        tab_data[j] = tab_data[j-1];
                    end
                    tab_key[slot]  = it.key;
                    tab_data[slot] = it.record_data;
                    tab_cnt++;
                    r.position = slot[POS_W-1:0];
                end
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int j = hit; j + 1 < tab_cnt; j++) begin
                        tab_key[j]  = tab_key[j+1];
                        tab_data[j] = tab_data[j+1];
                    end
                    tab_cnt--;
                    r.position = hit[POS_W-1:0];
                end
            end
            OP_FIND: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.position   = hit[POS_W-1:0];
                    r.found_data = tab_data[hit];
                end
            end
            default: ;
        endcase
        r.entry_count = tab_cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                           input logic [IN_DW-1:0] d);
        t_in_item it;
        it.opcode      = op;
        it.key         = k;
        it.record_data = d;
        return it;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic int sender_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        return gap_len();
    endfunction

    // keys biased toward present entries and their neighbors
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (tab_cnt > 0 && r < 45) return tab_key[$urandom_range(0, tab_cnt - 1)];
        if (tab_cnt > 0 && r < 60) begin
            if ($urandom_range(0, 1)) return tab_key[$urandom_range(0, tab_cnt - 1)] + 32'd1;
            return tab_key[$urandom_range(0, tab_cnt - 1)] - 32'd1;
        end
        if (r < 85) return key_pool[$urandom_range(0, 31)];
        return $urandom;
    endfunction

    // offer one item and record its expected result once it is taken
    task automatic send_item(input t_in_item it);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(table_apply(it));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // extremes of key and data, every operation, hits and misses at each end
    task automatic test_directed();
        send_item(make_item(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_item(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF));
        send_item(make_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555));
        send_item(make_item(OP_INSERT, 32'h7FFF_FFFF, 32'h1234_5678));
        send_item(make_item(OP_INSERT, 32'h0000_0000, 32'h5555_AAAA));
        send_item(make_item(OP_FIND,   32'h0000_0000, 32'h0000_0000));
        send_item(make_item(OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(OP_FIND,   32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_FIND,   32'h0000_0001, 32'h0000_0000));
        send_item(make_item(OP_DELETE, 32'h8000_0001, 32'h0000_0000));
        send_item(make_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000));
        send_item(make_item(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(OP_FIND,   32'h8000_0000, 32'h0000_0000));
        send_item(make_item(OP_DELETE, 32'h8000_0000, 32'h0000_0000));
        send_item(make_item(OP_DELETE, 32'h8000_0000, 32'h0000_0000));
        send_item(make_item(OP_RESERVED, 32'h0000_0000, 32'h0000_0000));
        wait_all_results();
    endtask

    // fill up, then full, duplicate and find cases on a full table, and refills at both ends
    task automatic test_full_table();
        while (tab_cnt < TABLE_DEPTH) send_item(make_item(OP_INSERT, $urandom, $urandom));
        send_item(make_item(OP_INSERT, $urandom, $urandom));
        send_item(make_item(OP_INSERT, tab_key[5], $urandom));
        send_item(make_item(OP_FIND, tab_key[0], $urandom));
        send_item(make_item(OP_FIND, tab_key[TABLE_DEPTH-1], $urandom));
        send_item(make_item(OP_RESERVED, $urandom, $urandom));
        send_item(make_item(OP_DELETE, tab_key[TABLE_DEPTH-1], $urandom));
        send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, $urandom));
        send_item(make_item(OP_DELETE, tab_key[0], $urandom));
        send_item(make_item(OP_INSERT, 32'h0000_0000, $urandom));
        send_item(make_item(OP_INSERT, $urandom, $urandom));
        wait_all_results();
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        @(posedge clk);
        rx_hold_left = 300;
        no_gaps = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_item(make_item(($urandom_range(0, 2) == 0) ? OP_DELETE : OP_FIND,
                                pick_key(), $urandom));
        end
        no_gaps = 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_ops(input int n, input int w_ins, input int w_del,
                                   input int w_find);
        int         r;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, w_ins + w_del + w_find + 3);
            if (r < w_ins) op = OP_INSERT;
            else if (r < w_ins + w_del) op = OP_DELETE;
            else if (r < w_ins + w_del + w_find) op = OP_FIND;
            else op = OP_RESERVED;
            send_item(make_item(op, pick_key(), $urandom));
        end
        wait_all_results();
    endtask

    // delete present keys, with some finds, until the table is empty, then a find and a delete
    task automatic test_drain_table();
        while (tab_cnt > 0) begin
            if ($urandom_range(0, 4) == 0)
                send_item(make_item(OP_FIND, tab_key[$urandom_range(0, tab_cnt - 1)], $urandom));
            else
                send_item(make_item(OP_DELETE, tab_key[$urandom_range(0, tab_cnt - 1)], $urandom));
        end
        send_item(make_item(OP_FIND, pick_key(), $urandom));
        send_item(make_item(OP_DELETE, pick_key(), $urandom));
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        @(posedge clk);
        no_gaps = 1'b1;
        test_random_ops(150, 35, 30, 30);
        no_gaps = 1'b0;
    endtask

    // receiver: random stalls, plus the long hold-off on request
    initial begin
        out_ready = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge clk);
            if (rx_hold_left > 0) begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end else if (no_gaps) begin
                out_ready <= 1'b1;
            end else if (rx_stall_left > 0) begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end else if ($urandom_range(0, 99) < 75) begin
                out_ready <= 1'b1;
            end else begin
                rx_stall_left = gap_len() - 1;
                out_ready <= 1'b0;
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk) begin
        t_out_item exp_item;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no item outstanding: %p", out_item);
                mismatches++;
            end else begin
                exp_item = pending_results.pop_front();
                if (out_item.status !== exp_item.status) begin
                    $error("status: expected %0d, got %0d", exp_item.status, out_item.status);
                    mismatches++;
                end
                if (out_item.position !== exp_item.position) begin
                    $error("position: expected %0d, got %0d",
                           exp_item.position, out_item.position);
                    mismatches++;
                end
                if (out_item.found_data !== exp_item.found_data) begin
                    $error("found_data: expected %h, got %h",
                           exp_item.found_data, out_item.found_data);
                    mismatches++;
                end
                if (out_item.entry_count !== exp_item.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_item.entry_count, out_item.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // main sequence
    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        tab_cnt = 0;
        mismatches = 0;
        no_gaps = 1'b0;
        rx_hold_left = 0;
        for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_backpressure();
        test_random_ops(300, 30, 30, 35);
        test_drain_table();
        test_random_ops(300, 50, 25, 20);
        test_back_to_back();
        test_random_ops(250, 25, 45, 25);

        wait_all_results();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_key_table_tb passed");
        end else begin
            $display("sorted_key_table_tb failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("sorted_key_table_tb failed");
        $finish;
    end

endmodule
